FILE: rtl/tcb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcb_pkg: shared types and constants for triangle coverage
// Widths of the fixed-point coordinate, area and weight paths, register
// codes, pipeline latencies, inside tolerance factors and the output colors.
// ----------------------------------------------------------------------------
package tcb_pkg;

  // field and register widths
  localparam int PIX_W  = 9;
  localparam int CFG_W  = 16;
  localparam int IDX_W  = 3;

  // q.20 coordinates: vertex register shifted left by VTX_SH
  localparam int VTX_SH = 4;
  localparam int VTX_W  = CFG_W + VTX_SH;

  // pixel centre numerator 2p+1 and its scaled reciprocal divide
  localparam int NUM_W    = PIX_W + 1;
  localparam int CEN_FRAC = 19;
  localparam int RECIP_SH = 10;
  localparam int RCP_W    = 30;
  localparam int PRD_W    = 44;
  localparam int QW       = 28;

  // cross product path
  localparam int DV_W = VTX_W + 1;
  localparam int DQ_W = QW + 1;
  localparam int PV_W = 2 * DV_W;
  localparam int PQ_W = DV_W + DQ_W;
  localparam int CR_W = PQ_W + 1;
  localparam int TC_W = PV_W + 1;
  localparam int AW   = CR_W;
  localparam int TW   = TC_W;
  localparam int SW   = AW + 2;
  localparam int IW   = SW + 8;

  // weight divide: divisor is total * 4, remainder stays below it
  localparam int WT_W      = 18;
  localparam int RW        = TW + 2;
  localparam int DIV_STEPS = WT_W;
  localparam logic [WT_W-1:0] WEIGHT_MAX = {WT_W{1'b1}};

  // bounding box products
  localparam int BOX_W = 32;

  // pipeline latencies
  localparam int COORD_LAT = 3;
  localparam int AREA_LAT  = 5;
  localparam int DIV_LAT   = DIV_STEPS + 1;

  // inside tolerance factors
  localparam int TOL_LO  = 99;
  localparam int TOL_MID = 100;
  localparam int TOL_HI  = 101;

  // colors
  localparam int COL_W = 8;
  localparam logic [COL_W-1:0] COL_HI  = 8'd200;
  localparam logic [COL_W-1:0] COL_LO  = 8'd50;
  localparam logic [COL_W-1:0] COL_MID = 8'd120;
  localparam logic [COL_W-1:0] COL_OFF = 8'd0;

  typedef enum logic [IDX_W-1:0] {
    REG_A_X = 3'd0,
    REG_A_Y = 3'd1,
    REG_B_X = 3'd2,
    REG_B_Y = 3'd3,
    REG_C_X = 3'd4,
    REG_C_Y = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [CFG_W-1:0] ax;
    logic [CFG_W-1:0] ay;
    logic [CFG_W-1:0] bx;
    logic [CFG_W-1:0] by;
    logic [CFG_W-1:0] cx;
    logic [CFG_W-1:0] cy;
  } vertex_t;

  typedef struct packed {
    logic [QW-1:0] qx;
    logic [QW-1:0] qy;
  } centre_t;

  typedef struct packed {
    logic [AW-1:0] a1;
    logic [AW-1:0] a2;
    logic [AW-1:0] a3;
    logic [TW-1:0] total;
    logic [SW-1:0] sum;
  } area_t;

endpackage

FILE: rtl/tcb_coord.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcb_coord: pixel centre coordinates
// Forms floor((2p+1) * 2^19 / dim) for both axes by a reciprocal multiply
// and a one-step correction, over three register stages.
// ----------------------------------------------------------------------------
module tcb_coord import tcb_pkg::*; #(
  parameter int IMAGE_WIDTH  = 512,
  parameter int IMAGE_HEIGHT = 512
) (
  input  logic             clk,
  input  logic             en,
  input  logic [PIX_W-1:0] pixel_x,
  input  logic [PIX_W-1:0] pixel_y,
  output centre_t          centre
);

  logic [QW-1:0] q_axis [2];

  for (genvar g = 0; g < 2; g++) begin : g_axis
    localparam int DIM = (g == 0) ? IMAGE_WIDTH : IMAGE_HEIGHT;
    localparam longint RECIP = (longint'(1) << (CEN_FRAC + RECIP_SH)) / DIM;

    logic [PIX_W-1:0]       pix;
    logic [NUM_W-1:0]       num_s1;
    logic [NUM_W-1:0]       num_s2;
    logic [NUM_W+RCP_W-1:0] prod;
    logic [QW-1:0]          q_est;
    logic [QW-1:0]          q_fix;
    logic [PRD_W-1:0]       back;
    logic [PRD_W-1:0]       rem;

    assign pix = (g == 0) ? pixel_x : pixel_y;

    // remainder of the estimate, below twice the divisor
    assign back = PRD_W'(q_est) * PRD_W'(DIM);
    assign rem  = (PRD_W'(num_s2) << CEN_FRAC) - back;

    // reciprocal multiply, scale down, correct by one
    always_ff @(posedge clk) begin
      if (en) begin
        num_s1 <= {pix, 1'b1};
        prod   <= (NUM_W + RCP_W)'({pix, 1'b1}) * (NUM_W + RCP_W)'(RCP_W'(RECIP));
        num_s2 <= num_s1;
        q_est  <= prod[RECIP_SH +: QW];
        q_fix  <= q_est + QW'(rem >= PRD_W'(DIM));
      end
    end

    assign q_axis[g] = q_fix;
  end

  assign centre.qx = q_axis[0];
  assign centre.qy = q_axis[1];

endmodule

FILE: rtl/tcb_area.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcb_area: twice the areas of the triangle and its three sub-triangles
// Edge differences, products, cross products, absolute values and the
// sub-area sum, one register stage each.
// ----------------------------------------------------------------------------
module tcb_area import tcb_pkg::*; (
  input  logic    clk,
  input  logic    en,
  input  vertex_t vtx,
  input  centre_t centre,
  output area_t   area
);

  // vertex coordinates, widened for vertex and point differences
  logic signed [DV_W-1:0] ax_v, ay_v, bx_v, by_v, cx_v, cy_v;
  logic signed [DQ_W-1:0] ax_q, ay_q, bx_q, by_q, cx_q, cy_q, qx_q, qy_q;

  assign ax_v = $signed({1'b0, vtx.ax, {VTX_SH{1'b0}}});
  assign ay_v = $signed({1'b0, vtx.ay, {VTX_SH{1'b0}}});
  assign bx_v = $signed({1'b0, vtx.bx, {VTX_SH{1'b0}}});
  assign by_v = $signed({1'b0, vtx.by, {VTX_SH{1'b0}}});
  assign cx_v = $signed({1'b0, vtx.cx, {VTX_SH{1'b0}}});
  assign cy_v = $signed({1'b0, vtx.cy, {VTX_SH{1'b0}}});

  assign ax_q = $signed({{(DQ_W-VTX_W){1'b0}}, vtx.ax, {VTX_SH{1'b0}}});
  assign ay_q = $signed({{(DQ_W-VTX_W){1'b0}}, vtx.ay, {VTX_SH{1'b0}}});
  assign bx_q = $signed({{(DQ_W-VTX_W){1'b0}}, vtx.bx, {VTX_SH{1'b0}}});
  assign by_q = $signed({{(DQ_W-VTX_W){1'b0}}, vtx.by, {VTX_SH{1'b0}}});
  assign cx_q = $signed({{(DQ_W-VTX_W){1'b0}}, vtx.cx, {VTX_SH{1'b0}}});
  assign cy_q = $signed({{(DQ_W-VTX_W){1'b0}}, vtx.cy, {VTX_SH{1'b0}}});
  assign qx_q = $signed({1'b0, centre.qx});
  assign qy_q = $signed({1'b0, centre.qy});

  logic signed [DV_W-1:0] e1x, e1y, e2x, e2y, e3x, e3y, gx, gy;
  logic signed [DQ_W-1:0] f1x, f1y, f2x, f2y, f3x, f3y;
  logic signed [PQ_W-1:0] p1a, p1b, p2a, p2b, p3a, p3b;
  logic signed [PV_W-1:0] pta, ptb;
  logic signed [CR_W-1:0] c1, c2, c3;
  logic signed [TC_W-1:0] ct;
  logic [AW-1:0]          a1, a2, a3;
  logic [TW-1:0]          tot;

  always_ff @(posedge clk) begin
    if (en) begin
      // edge and point differences
      e1x <= cx_v - bx_v;  e1y <= cy_v - by_v;
      e2x <= ax_v - cx_v;  e2y <= ay_v - cy_v;
      e3x <= bx_v - ax_v;  e3y <= by_v - ay_v;
      gx  <= cx_v - ax_v;  gy  <= cy_v - ay_v;
      f1x <= qx_q - bx_q;  f1y <= qy_q - by_q;
      f2x <= qx_q - cx_q;  f2y <= qy_q - cy_q;
      f3x <= qx_q - ax_q;  f3y <= qy_q - ay_q;

      // cross product terms
      p1a <= PQ_W'(e1x) * PQ_W'(f1y);
      p1b <= PQ_W'(e1y) * PQ_W'(f1x);
      p2a <= PQ_W'(e2x) * PQ_W'(f2y);
      p2b <= PQ_W'(e2y) * PQ_W'(f2x);
      p3a <= PQ_W'(e3x) * PQ_W'(f3y);
      p3b <= PQ_W'(e3y) * PQ_W'(f3x);
      pta <= PV_W'(e3x) * PV_W'(gy);
      ptb <= PV_W'(e3y) * PV_W'(gx);

      // signed cross products
      c1 <= CR_W'(p1a) - CR_W'(p1b);
      c2 <= CR_W'(p2a) - CR_W'(p2b);
      c3 <= CR_W'(p3a) - CR_W'(p3b);
      ct <= TC_W'(pta) - TC_W'(ptb);

      // magnitudes
      a1  <= c1[CR_W-1] ? AW'(-c1) : AW'(c1);
      a2  <= c2[CR_W-1] ? AW'(-c2) : AW'(c2);
      a3  <= c3[CR_W-1] ? AW'(-c3) : AW'(c3);
      tot <= ct[TC_W-1] ? TW'(-ct) : TW'(ct);

      // sub-area sum
      area.a1    <= a1;
      area.a2    <= a2;
      area.a3    <= a3;
      area.total <= tot;
      area.sum   <= SW'(a1) + SW'(a2) + SW'(a3);
    end
  end

endmodule

FILE: rtl/tcb_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcb_div: pipelined weight divider
// floor(part * 2^16 / total) with saturation and zero-total handling,
// one restoring quotient bit per register stage after a setup stage.
// ----------------------------------------------------------------------------
module tcb_div import tcb_pkg::*; (
  input  logic            clk,
  input  logic            en,
  input  logic [AW-1:0]   part,
  input  logic [TW-1:0]   total,
  output logic [WT_W-1:0] weight
);

  logic [RW-1:0]   rem  [DIV_LAT];
  logic [RW-1:0]   dvs  [DIV_LAT];
  logic [WT_W-1:0] quo  [DIV_LAT];
  logic            zero [DIV_LAT];
  logic            sat  [DIV_LAT];

  logic [RW-1:0] dvs_in;
  logic          sat_in;

  assign dvs_in = {total, 2'b00};
  assign sat_in = part >= AW'(dvs_in);

  // setup: divisor is total * 4 so the dividend part * 2^18 needs 18 steps
  always_ff @(posedge clk) begin
    if (en) begin
      zero[0] <= (total == '0);
      sat[0]  <= sat_in;
      dvs[0]  <= dvs_in;
      rem[0]  <= sat_in ? '0 : part[RW-1:0];
      quo[0]  <= '0;
    end
  end

  // one quotient bit per stage
  for (genvar k = 1; k < DIV_LAT; k++) begin : g_step
    logic [RW:0] dbl;
    logic        ge;

    assign dbl = {rem[k-1], 1'b0};
    assign ge  = dbl >= {1'b0, dvs[k-1]};

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k]  <= ge ? RW'(dbl - {1'b0, dvs[k-1]}) : RW'(dbl);
        dvs[k]  <= dvs[k-1];
        quo[k]  <= {quo[k-1][WT_W-2:0], ge};
        zero[k] <= zero[k-1];
        sat[k]  <= sat[k-1];
      end
    end
  end

  assign weight = zero[DIV_LAT-1] ? '0 :
                  sat[DIV_LAT-1]  ? WEIGHT_MAX : quo[DIV_LAT-1];

endmodule

FILE: rtl/triangle_coverage_barycentric.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_coverage_barycentric: barycentric point-in-triangle test
// Tests one pixel centre per item against a configured triangle and returns
// the inside flag, bounding-box flag, three Q2.16 weights and a color.
// ----------------------------------------------------------------------------
// One pixel enters per clock while the pipeline advances and passes 27 register
// stages: three stages form the pixel centre, five build the cross-product
// areas, and the three weight dividers take a setup stage plus one stage per
// quotient bit (18). The whole pipeline advances together: when the result in
// the output stage is not taken, every stage holds and s_tready drops. Vertex
// registers are to be written only while no item is in flight.
module triangle_coverage_barycentric import tcb_pkg::*; #(
  parameter int IMAGE_WIDTH  = 512,
  parameter int IMAGE_HEIGHT = 512
) (
  input  logic             clk,
  input  logic             rst,
  // configuration write port
  input  logic             cfg_wr_en,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  // pixel items
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [23:0]      s_tdata,   // pixel_x, pixel_y, zero fill
  // result items
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [79:0]      m_tdata    // inside_res, in_box, weight_a, weight_b,
                                      // weight_c, red, green, blue
);

  localparam int LAT = COORD_LAT + AREA_LAT + DIV_LAT;

  vertex_t vtx;
  logic    adv;
  logic [LAT-1:0] vld;
  logic [LAT-1:0] box_pipe;
  logic [DIV_LAT-1:0] ins_pipe;

  // vertex registers
  always_ff @(posedge clk) begin
    if (rst) begin
      vtx.ax <= 16'd32768;
      vtx.ay <= 16'd13107;
      vtx.bx <= 16'd45875;
      vtx.by <= 16'd32768;
      vtx.cx <= 16'd19661;
      vtx.cy <= 16'd52429;
    end else if (cfg_wr_en) begin
      case (reg_idx_t'(cfg_index))
        REG_A_X: vtx.ax <= cfg_data;
        REG_A_Y: vtx.ay <= cfg_data;
        REG_B_X: vtx.bx <= cfg_data;
        REG_B_Y: vtx.by <= cfg_data;
        REG_C_X: vtx.cx <= cfg_data;
        REG_C_Y: vtx.cy <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline advance and valid chain
  assign adv      = !vld[LAT-1] || m_tready;
  assign s_tready = adv;
  assign m_tvalid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-2:0], s_tvalid};
    end
  end

  logic [PIX_W-1:0] pixel_x;
  logic [PIX_W-1:0] pixel_y;

  assign pixel_x = s_tdata[PIX_W-1:0];
  assign pixel_y = s_tdata[2*PIX_W-1:PIX_W];

  // bounding box limits
  logic [CFG_W-1:0] lo_x, hi_x, lo_y, hi_y, m_x, n_x, m_y, n_y;
  logic [BOX_W-1:0] lo_x_prod, hi_x_prod, lo_y_prod, hi_y_prod;
  logic             box_hit;

  assign m_x  = (vtx.ax < vtx.bx) ? vtx.ax : vtx.bx;
  assign lo_x = (m_x < vtx.cx) ? m_x : vtx.cx;
  assign n_x  = (vtx.ax > vtx.bx) ? vtx.ax : vtx.bx;
  assign hi_x = (n_x > vtx.cx) ? n_x : vtx.cx;
  assign m_y  = (vtx.ay < vtx.by) ? vtx.ay : vtx.by;
  assign lo_y = (m_y < vtx.cy) ? m_y : vtx.cy;
  assign n_y  = (vtx.ay > vtx.by) ? vtx.ay : vtx.by;
  assign hi_y = (n_y > vtx.cy) ? n_y : vtx.cy;

  assign lo_x_prod = BOX_W'(lo_x) * BOX_W'(IMAGE_WIDTH);
  assign hi_x_prod = BOX_W'(hi_x) * BOX_W'(IMAGE_WIDTH);
  assign lo_y_prod = BOX_W'(lo_y) * BOX_W'(IMAGE_HEIGHT);
  assign hi_y_prod = BOX_W'(hi_y) * BOX_W'(IMAGE_HEIGHT);

  assign box_hit = (CFG_W'(pixel_x) >= lo_x_prod[BOX_W-1:CFG_W]) &&
                   ((BOX_W'(pixel_x) << CFG_W) < hi_x_prod) &&
                   (CFG_W'(pixel_y) >= lo_y_prod[BOX_W-1:CFG_W]) &&
                   ((BOX_W'(pixel_y) << CFG_W) < hi_y_prod);

  // box flag travels alongside the item
  always_ff @(posedge clk) begin
    if (adv) begin
      box_pipe <= {box_pipe[LAT-2:0], box_hit};
    end
  end

  // pixel centre and areas
  centre_t centre;
  area_t   area;

  tcb_coord #(
    .IMAGE_WIDTH  (IMAGE_WIDTH),
    .IMAGE_HEIGHT (IMAGE_HEIGHT)
  ) u_coord (
    .clk     (clk),
    .en      (adv),
    .pixel_x (pixel_x),
    .pixel_y (pixel_y),
    .centre  (centre)
  );

  tcb_area u_area (
    .clk    (clk),
    .en     (adv),
    .vtx    (vtx),
    .centre (centre),
    .area   (area)
  );

  // one percent window on the sub-area sum
  logic [IW-1:0] tot_lo, tot_hi, sum_mid;
  logic          inside_now;

  assign tot_lo  = IW'(area.total) * IW'(TOL_LO);
  assign tot_hi  = IW'(area.total) * IW'(TOL_HI);
  assign sum_mid = IW'(area.sum) * IW'(TOL_MID);
  assign inside_now = (area.total != '0) && (tot_lo < sum_mid) && (sum_mid < tot_hi);

  always_ff @(posedge clk) begin
    if (adv) begin
      ins_pipe <= {ins_pipe[DIV_LAT-2:0], inside_now};
    end
  end

  // weight dividers
  logic [WT_W-1:0] weight_a, weight_b, weight_c;

  tcb_div u_div_a (
    .clk (clk), .en (adv), .part (area.a1), .total (area.total), .weight (weight_a)
  );

  tcb_div u_div_b (
    .clk (clk), .en (adv), .part (area.a2), .total (area.total), .weight (weight_b)
  );

  tcb_div u_div_c (
    .clk (clk), .en (adv), .part (area.a3), .total (area.total), .weight (weight_c)
  );

  // color and result packing
  logic inside_res, in_box;
  logic [COL_W-1:0] red, green, blue;

  assign inside_res = ins_pipe[DIV_LAT-1];
  assign in_box     = box_pipe[LAT-1];

  always_comb begin
    if (!in_box) begin
      red = COL_OFF;  green = COL_MID; blue = COL_MID;
    end else if (inside_res) begin
      red = COL_HI;   green = COL_LO;  blue = COL_LO;
    end else begin
      red = COL_MID;  green = COL_OFF; blue = COL_MID;
    end
  end

  assign m_tdata = {blue, green, red, weight_c, weight_b, weight_a, in_box, inside_res};

  // checks
  logic [WT_W+1:0] weight_sum;
  assign weight_sum = (WT_W+2)'(weight_a) + (WT_W+2)'(weight_b) + (WT_W+2)'(weight_c);

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> vld[0])
    else $error("accepted item did not enter the pipeline");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_weight_sum: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && inside_res) |-> (weight_sum <= 20'd66191 && weight_sum >= 20'd64877))
    else $error("weights of an inside pixel do not sum to about one");

endmodule
